// ----- rtl/lzd_pkg.sv -----
`default_nettype none

package lzd_pkg;

  localparam int unsigned HIST_DEPTH  = 256;
  localparam int unsigned HIST_AW     = $clog2(HIST_DEPTH);
  localparam int unsigned BPR_DEFAULT = 8;
  localparam int unsigned MAX_RESULTS = 33;
  localparam int unsigned RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned OLEN_W      = 24;
  localparam int unsigned OUT_W       = 64;
  localparam int unsigned BCNT_W      = 4;
  localparam int unsigned CMDQ_DEPTH  = 2;
  localparam int unsigned CMDQ_PW     = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CW     = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic {
    CMD_FILL,
    CMD_COPY
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_OFFSET  = 2'd1,
    ERR_LIT_EXT = 2'd2
  } err_code_e;

  typedef struct packed {
    logic             lit_valid;
    logic [7:0]       lit_byte;
    cmd_kind_e        kind;
    logic [CNT_W-1:0] count;
    logic [7:0]       offset;
    logic             done;
    err_code_e        err;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/lzd_ram.sv -----
`default_nettype none

module lzd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/lzd_front.sv -----
`default_nettype none

module lzd_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire logic [7:0]                  in_byte_i,
  input  wire logic [lzd_pkg::OLEN_W-1:0]  olen_i,
  output lzd_pkg::cmd_t                    cmd_o
);

  import lzd_pkg::*;

  localparam logic [2:0] PH_TOKEN    = 3'd0;
  localparam logic [2:0] PH_LIT_EXT  = 3'd1;
  localparam logic [2:0] PH_LEN_EXT  = 3'd2;
  localparam logic [2:0] PH_LITERALS = 3'd3;
  localparam logic [2:0] PH_OFFSET   = 3'd4;

  logic [2:0]        phase_q, phase_d;
  logic [7:0]        lit_q, lit_d;
  logic [7:0]        run_q, run_d;
  logic              match_q, match_d;
  logic [OLEN_W-1:0] bw_q, bw_d;
  logic              done_q, done_d;
  err_code_e         err_q, err_d;

  logic              hdr, aft, tok_end, emit_lit, copy_go, zero_run;
  logic [CNT_W-1:0]  cnt;
  logic [OLEN_W:0]   bw_sum;

  always_comb begin
    phase_d  = phase_q;
    lit_d    = lit_q;
    run_d    = run_q;
    match_d  = match_q;
    err_d    = err_q;
    hdr      = 1'b0;
    aft      = 1'b0;
    tok_end  = 1'b0;
    emit_lit = 1'b0;
    copy_go  = 1'b0;
    zero_run = 1'b0;

    if (!done_q && err_q == ERR_NONE) begin
      unique case (phase_q)
        PH_TOKEN: begin
          match_d = in_byte_i[3];
          run_d   = {4'd0, in_byte_i[7:4]};
          if (in_byte_i[2:0] == 3'd0) begin
            phase_d = PH_LIT_EXT;
          end else begin
            lit_d = {5'd0, in_byte_i[2:0] - 3'd1};
            if (in_byte_i[7:4] == 4'd0) begin
              phase_d = PH_LEN_EXT;
            end else begin
              hdr = 1'b1;
            end
          end
        end
        PH_LIT_EXT: begin
          if (in_byte_i == 8'd0) begin
            err_d   = ERR_LIT_EXT;
            phase_d = PH_TOKEN;
          end else begin
            lit_d = in_byte_i - 8'd1;
            if (run_q == 8'd0) begin
              phase_d = PH_LEN_EXT;
            end else begin
              hdr = 1'b1;
            end
          end
        end
        PH_LEN_EXT: begin
          run_d = in_byte_i;
          hdr   = 1'b1;
        end
        PH_LITERALS: begin
          emit_lit = 1'b1;
          lit_d    = lit_q - 8'd1;
          if (lit_q == 8'd1) begin
            aft = 1'b1;
          end
        end
        PH_OFFSET: begin
          phase_d = PH_TOKEN;
          if (in_byte_i == 8'd0) begin
            err_d = ERR_OFFSET;
          end else begin
            copy_go = 1'b1;
            tok_end = 1'b1;
          end
        end
        default: begin
          phase_d = PH_TOKEN;
        end
      endcase

      if (hdr) begin
        if (lit_d != 8'd0) begin
          phase_d = PH_LITERALS;
        end else begin
          aft = 1'b1;
        end
      end

      if (aft) begin
        if (match_d) begin
          phase_d = PH_OFFSET;
        end else begin
          zero_run = 1'b1;
          tok_end  = 1'b1;
          phase_d  = PH_TOKEN;
        end
      end
    end
  end

  always_comb begin
    if (copy_go) begin
      cnt = {1'b0, run_q} + CNT_W'(2);
    end else begin
      cnt = CNT_W'(emit_lit) + (zero_run ? {1'b0, run_d} : CNT_W'(0));
    end
    bw_sum = {1'b0, bw_q} + (OLEN_W + 1)'(cnt);
    bw_d   = bw_sum[OLEN_W] ? '1 : bw_sum[OLEN_W-1:0];
    done_d = done_q | (tok_end && (bw_d >= olen_i));
  end

  always_comb begin
    cmd_o.lit_valid = emit_lit;
    cmd_o.lit_byte  = in_byte_i;
    cmd_o.kind      = copy_go ? CMD_COPY : CMD_FILL;
    cmd_o.count     = cnt;
    cmd_o.offset    = in_byte_i;
    cmd_o.done      = done_d;
    cmd_o.err       = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOKEN;
      lit_q   <= '0;
      run_q   <= '0;
      match_q <= 1'b0;
      bw_q    <= '0;
      done_q  <= 1'b0;
      err_q   <= ERR_NONE;
    end else if (push_i) begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      run_q   <= run_d;
      match_q <= match_d;
      bw_q    <= bw_d;
      done_q  <= done_d;
      err_q   <= err_d;
    end
  end

`ifndef SYNTHESIS
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("finish flag dropped");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ERR_NONE |=> err_q == $past(err_q))
    else $error("error latch changed");
`endif

endmodule

`default_nettype wire

// ----- rtl/lzd_fifo.sv -----
`default_nettype none

module lzd_fifo (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire lzd_pkg::cmd_t push_data_i,
  input  wire logic  pop_i,
  output lzd_pkg::cmd_t pop_data_o,
  output logic       full_o,
  output logic       empty_o
);

  import lzd_pkg::*;

  cmd_t               entry_q [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0] wr_ptr_q;
  logic [CMDQ_PW-1:0] rd_ptr_q;
  logic [CMDQ_CW-1:0] cnt_q;

  assign full_o     = (cnt_q == CMDQ_CW'(CMDQ_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + CMDQ_PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + CMDQ_PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CMDQ_CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CMDQ_CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |=> cnt_q == CMDQ_CW'(CMDQ_DEPTH) && !$past(push_i))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue underflow");
`endif

endmodule

`default_nettype wire

// ----- rtl/lzd_back.sv -----
`default_nettype none

module lzd_back #(
  parameter int unsigned BYTES_PER_RESULT = lzd_pkg::BPR_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       empty_i,
  input  wire lzd_pkg::cmd_t              head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [lzd_pkg::OUT_W-1:0]       out_bytes_o,
  output logic [lzd_pkg::BCNT_W-1:0]      byte_count_o,
  output logic                            last_o,
  output logic                            finished_o,
  output logic [1:0]                      error_code_o
);

  import lzd_pkg::*;

  localparam int unsigned PW = 8 * BYTES_PER_RESULT;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state_q, state_d;
  logic               lit_pend_q, lit_pend_d;
  logic [7:0]         lit_byte_q, lit_byte_d;
  logic               copy_q, copy_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [7:0]         off_q, off_d;
  logic               done_q, done_d;
  err_code_e          err_q, err_d;
  logic [PW-1:0]      word_q, word_d;
  logic [BCNT_W-1:0]  fill_q, fill_d;
  logic [RES_W-1:0]   res_q, res_d;
  logic [HIST_AW-1:0] hp_q;
  logic [HIST_DEPTH-1:0] hvalid_q;
  logic               rd_valid_q;

  logic               out_valid_q;
  logic [OUT_W-1:0]   out_bytes_q;
  logic [BCNT_W-1:0]  out_cnt_q;
  logic               out_last_q;
  logic               out_done_q;
  err_code_e          out_err_q;

  logic               ram_we, ram_re;
  logic [HIST_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;
  logic [7:0]         cur_byte;
  logic [PW-1:0]      new_word;
  logic               has_byte, final_byte, flush, keep, go, out_free, out_load;

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (hp_q),
    .wdata_i (cur_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign ram_raddr = hp_q - off_q;
  assign has_byte  = (cnt_q != '0);
  assign final_byte = (cnt_q <= CNT_W'(1));
  assign flush     = final_byte || (fill_q == BCNT_W'(BYTES_PER_RESULT - 1));
  assign keep      = (res_q < RES_W'(MAX_RESULTS));

  always_comb begin
    if (lit_pend_q) begin
      cur_byte = lit_byte_q;
    end else if (copy_q && rd_valid_q) begin
      cur_byte = ram_rdata;
    end else begin
      cur_byte = 8'd0;
    end
  end

  always_comb begin
    new_word = word_q;
    for (int i = 0; i < int'(BYTES_PER_RESULT); i++) begin
      if (fill_q == BCNT_W'(i)) begin
        new_word[8*i +: 8] = cur_byte;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    lit_pend_d = lit_pend_q;
    lit_byte_d = lit_byte_q;
    copy_d     = copy_q;
    cnt_d      = cnt_q;
    off_d      = off_q;
    done_d     = done_q;
    err_d      = err_q;
    word_d     = word_q;
    fill_d     = fill_q;
    res_d      = res_q;
    pop_o      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    go         = 1'b0;
    out_load   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o      = 1'b1;
          lit_pend_d = head_i.lit_valid;
          lit_byte_d = head_i.lit_byte;
          copy_d     = (head_i.kind == CMD_COPY);
          cnt_d      = head_i.count;
          off_d      = head_i.offset;
          done_d     = head_i.done;
          err_d      = head_i.err;
          word_d     = '0;
          fill_d     = '0;
          res_d      = '0;
          state_d    = (head_i.kind == CMD_COPY && head_i.count != '0 && !head_i.lit_valid)
                       ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        go = !(flush && keep) || out_free;
        if (go) begin
          if (has_byte) begin
            ram_we     = 1'b1;
            cnt_d      = cnt_q - CNT_W'(1);
            lit_pend_d = 1'b0;
            word_d     = new_word;
            fill_d     = fill_q + BCNT_W'(1);
          end
          if (flush) begin
            word_d   = '0;
            fill_d   = '0;
            out_load = keep;
            if (keep) begin
              res_d = res_q + RES_W'(1);
            end
          end
          if (final_byte) begin
            state_d = ST_IDLE;
          end else if (copy_q) begin
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    lit_byte_q <= lit_byte_d;
    off_q      <= off_d;
    word_q     <= word_d;
    if (out_load) begin
      out_bytes_q <= OUT_W'(new_word);
      out_cnt_q   <= has_byte ? fill_q + BCNT_W'(1) : BCNT_W'(0);
      out_last_q  <= final_byte || (res_q == RES_W'(MAX_RESULTS - 1));
      out_done_q  <= done_q;
      out_err_q   <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lit_pend_q  <= 1'b0;
      copy_q      <= 1'b0;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      err_q       <= ERR_NONE;
      fill_q      <= '0;
      res_q       <= '0;
      hp_q        <= '0;
      hvalid_q    <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      lit_pend_q <= lit_pend_d;
      copy_q     <= copy_d;
      cnt_q      <= cnt_d;
      done_q     <= done_d;
      err_q      <= err_d;
      fill_q     <= fill_d;
      res_q      <= res_d;
      if (ram_we) begin
        hp_q           <= hp_q + HIST_AW'(1);
        hvalid_q[hp_q] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid_q <= hvalid_q[ram_raddr];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_bytes_o  = out_bytes_q;
  assign byte_count_o = out_cnt_q;
  assign last_o       = out_last_q;
  assign finished_o   = out_done_q;
  assign error_code_o = out_err_q;

`ifndef SYNTHESIS
  a_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_EMIT)
    else $error("history read not followed by emit");

  a_hp_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ram_we |=> hp_q == $past(hp_q))
    else $error("history pointer moved without a write");
`endif

endmodule

`default_nettype wire

// ----- rtl/lz_byte_stream_decompressor.sv -----
// LZ byte stream decompressor.
// Input channel: one compressed byte per transaction on in_byte_i, handshake
// in_valid_i / in_stall_o. Output channel: packed decoded bytes (first byte in
// bits 7:0) with byte_count_o, last_o, finished_o and error_code_o, handshake
// out_valid_o / out_stall_i. Every input byte yields one or more results; the
// final one carries last_o, a byte that decodes nothing yields one result with
// byte_count_o of zero.
// cfg_wr_en_i writes cfg_wr_data_i into the output length register; write it
// only while the block is idle.
// The parser takes one byte per cycle while its two-entry command queue has
// room, and keeps taking bytes while the executor is still busy. The executor
// loads a command in its idle state, then emits each literal or zero-run byte
// (or a status-only result) from its emit state; each back-reference byte also
// passes through a read state for the registered read of the 256-byte history.
// Reset clears the parser, history (read as zero until written), counters
// and the output valid flag. A stall on the output holds the current result;
// the executor and then the parser back up behind it.
`default_nettype none

module lz_byte_stream_decompressor #(
  parameter int unsigned BYTES_PER_RESULT = lzd_pkg::BPR_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_wr_en_i,
  input  wire logic [lzd_pkg::OLEN_W-1:0] cfg_wr_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 in_byte_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [lzd_pkg::OUT_W-1:0]       out_bytes_o,
  output logic [lzd_pkg::BCNT_W-1:0]      byte_count_o,
  output logic                            last_o,
  output logic                            finished_o,
  output logic [1:0]                      error_code_o
);

  import lzd_pkg::*;

  logic [OLEN_W-1:0] olen_q;
  logic              push, pop, full, empty;
  cmd_t              push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      olen_q <= '0;
    end else if (cfg_wr_en_i) begin
      olen_q <= cfg_wr_data_i;
    end
  end

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  lzd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_byte_i (in_byte_i),
    .olen_i    (olen_q),
    .cmd_o     (push_cmd)
  );

  lzd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .full_o      (full),
    .empty_o     (empty)
  );

  lzd_back #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_bytes_o  (out_bytes_o),
    .byte_count_o (byte_count_o),
    .last_o       (last_o),
    .finished_o   (finished_o),
    .error_code_o (error_code_o)
  );

endmodule

`default_nettype wire
